[sv/crlem_pkg.sv]
// Shared constants, register indexes, the log2 table generator and the
// smoothing function of the counter rate monitor. No dependencies.
package crlem_pkg;

    localparam int LEVEL_W      = 16;
    localparam int CNT_W        = 64;
    localparam int NUM_CNT      = 8;
    localparam int NUM_LEVEL    = 7;
    localparam int NUM_FS       = 6;
    localparam int LOG_IDX_W    = 6;
    localparam int LOG_TAB_SIZE = 1 << LOG_IDX_W;
    localparam int LOG_FRAC     = 24;
    localparam int LOG_W        = 30;
    localparam int DEN_W        = 26;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int S_DATA_W     = 544;
    localparam int M_DATA_W     = 128;

    localparam logic [15:0] ALPHA_98  = 16'd64225;
    localparam logic [15:0] ALPHA_MEM = 16'd61014;

    // Counters whose rate is taken in kB/s: rx, tx, read, write.
    localparam logic [NUM_CNT-1:0] KB_LANES = 8'b0011_0110;

    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTHING  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXEC_FS    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NET_FS     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SWITCH_FS  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_IO_FS      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RETX_FS    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_IRQ_FS     = 3'd6;

    // log2(1 + idx/N) in Q.24, by repeated squaring of a Q2.30 value.
    function automatic logic [LOG_FRAC:0] log_tab_entry(input int idx);
        logic [63:0]         x;
        logic [LOG_FRAC:0]   y;
        if (idx >= LOG_TAB_SIZE) begin
            return (LOG_FRAC + 1)'(1) << LOG_FRAC;
        end
        x = (64'd1 << 30) + ((64'(idx) << 30) / LOG_TAB_SIZE);
        y = '0;
        for (int b = 0; b < LOG_FRAC; b++) begin
            x = (x * x) >> 30;
            y = y << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                y[0] = 1'b1;
            end
        end
        return y;
    endfunction

    // (a*prev + (1-a)*x) with rounding, all Q0.16.
    function automatic logic [LEVEL_W-1:0] smooth(input logic [LEVEL_W-1:0] prev,
                                                  input logic [LEVEL_W-1:0] x,
                                                  input logic [15:0]        a);
        logic [32:0] p1;
        logic [32:0] p2;
        logic [33:0] s;
        p1 = 33'(a) * 33'(prev);
        p2 = 33'(17'h10000 - 17'(a)) * 33'(x);
        s  = 34'(p1) + 34'(p2) + 34'd32768;
        return s[31:16];
    endfunction

endpackage

[sv/crlem_rate_lane.sv]
// One rate lane: scales a counter delta by 1000*2^16 and divides it by the
// interval, one quotient bit per cycle. Uses crlem_pkg.
module crlem_rate_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [crlem_pkg::CNT_W-1:0]   delta,
    input  logic [crlem_pkg::DEN_W-1:0]   den,
    output logic                          busy,
    output logic [crlem_pkg::CNT_W-1:0]   rate
);

    typedef enum logic [2:0] {
        RT_IDLE = 3'b001,
        RT_CHK  = 3'b010,
        RT_DIV  = 3'b100
    } rt_state_t;

    rt_state_t   state_reg;
    logic [73:0] n_reg;
    logic [25:0] rem_reg;
    logic [63:0] low_reg;
    logic [5:0]  cnt_reg;
    logic [26:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg, low_reg[63]};
    assign ge     = rem_sh >= {1'b0, den};
    assign busy   = state_reg != RT_IDLE;
    assign rate   = low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RT_IDLE;
        end else begin
            unique case (state_reg)
                RT_IDLE: if (start) state_reg <= RT_CHK;
                RT_CHK: begin
                    if (n_reg[73:48] >= den) state_reg <= RT_IDLE;
                    else state_reg <= RT_DIV;
                end
                RT_DIV: if (cnt_reg == '0) state_reg <= RT_IDLE;
                default: state_reg <= RT_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            RT_IDLE: begin
                if (start) n_reg <= 74'(delta) * 74'd1000;
            end
            RT_CHK: begin
                // A quotient of 2^64 or more saturates.
                if (n_reg[73:48] >= den) begin
                    low_reg <= '1;
                end else begin
                    rem_reg <= n_reg[73:48];
                    low_reg <= {n_reg[47:0], 16'd0};
                    cnt_reg <= 6'd63;
                end
            end
            RT_DIV: begin
                rem_reg <= ge ? 26'(rem_sh - {1'b0, den}) : rem_sh[25:0];
                low_reg <= {low_reg[62:0], ge};
                cnt_reg <= cnt_reg - 6'd1;
            end
            default: ;
        endcase
    end

endmodule

[sv/crlem_level_lane.sv]
// One level lane: log2 of the rate and of the full scale, their ratio and
// the exponential average that holds the lane's level. Uses crlem_pkg.
module crlem_level_lane (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [crlem_pkg::CNT_W-1:0]     rate,
    input  logic [31:0]                     full_scale,
    input  logic [15:0]                     alpha,
    output logic                            busy,
    output logic [crlem_pkg::LEVEL_W-1:0]   level
);

    localparam int IW = crlem_pkg::LOG_IDX_W;
    localparam int LW = crlem_pkg::LOG_W;
    localparam int FW = crlem_pkg::LOG_FRAC;

    typedef enum logic [5:0] {
        LV_IDLE   = 6'b000001,
        LV_NORM   = 6'b000010,
        LV_INTERP = 6'b000100,
        LV_MUL    = 6'b001000,
        LV_DIV    = 6'b010000,
        LV_SMOOTH = 6'b100000
    } lv_state_t;

    lv_state_t          state_reg;
    logic [63:0]        x_reg;
    logic [5:0]         p_reg;
    logic [2:0]         step_reg;
    logic               pass_reg;
    logic [LW-1:0]      base_reg;
    logic [56:0]        prod_reg;
    logic [LW-1:0]      lr_reg;
    logic [LW-1:0]      lf_reg;
    logic [LW-1:0]      rem_reg;
    logic [15:0]        q_reg;
    logic [3:0]         cnt_reg;
    logic [15:0]        level_reg;

    logic [FW:0]        log_tab [0:crlem_pkg::LOG_TAB_SIZE];
    logic [6:0]         sh;
    logic               hi_zero;
    logic [IW-1:0]      idx;
    logic [IW:0]        idx_n;
    logic [31:0]        frac;
    logic [FW:0]        t0;
    logic [FW:0]        t1;
    logic [LW-1:0]      log_val;
    logic [64:0]        rate_sum;
    logic [63:0]        rate_p1;
    logic [63:0]        fs_x;
    logic [LW:0]        rem_sh;
    logic               ge;

    for (genvar g = 0; g <= crlem_pkg::LOG_TAB_SIZE; g++) begin : g_tab
        assign log_tab[g] = crlem_pkg::log_tab_entry(g);
    end

    assign sh       = 7'd1 << step_reg;
    assign hi_zero  = (x_reg >> (7'd64 - sh)) == 64'd0;
    assign idx      = x_reg[62 -: IW];
    assign idx_n    = (IW + 1)'(idx) + (IW + 1)'(1);
    assign frac     = {x_reg[62-IW -: 32-IW], IW'(0)};
    assign t0       = log_tab[idx];
    assign t1       = log_tab[idx_n];
    assign log_val  = base_reg + LW'(prod_reg[56:32]);
    assign rate_sum = {1'b0, rate} + 65'h10000;
    assign rate_p1  = rate_sum[64] ? '1 : rate_sum[63:0];
    assign fs_x     = {15'd0, 33'(full_scale) + 33'd1, 16'd0};
    assign rem_sh   = {rem_reg, 1'b0};
    assign ge       = rem_sh >= {1'b0, lf_reg};
    assign busy     = state_reg != LV_IDLE;
    assign level    = level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LV_IDLE;
            level_reg <= '0;
        end else begin
            unique case (state_reg)
                LV_IDLE:   if (start) state_reg <= LV_NORM;
                LV_NORM:   if (step_reg == '0) state_reg <= LV_INTERP;
                LV_INTERP: state_reg <= LV_MUL;
                LV_MUL: begin
                    if (!pass_reg) state_reg <= LV_NORM;
                    else if (log_val == '0 || lr_reg >= log_val) state_reg <= LV_SMOOTH;
                    else state_reg <= LV_DIV;
                end
                LV_DIV:    if (cnt_reg == '0) state_reg <= LV_SMOOTH;
                LV_SMOOTH: begin
                    level_reg <= crlem_pkg::smooth(level_reg, q_reg, alpha);
                    state_reg <= LV_IDLE;
                end
                default: state_reg <= LV_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            LV_IDLE: begin
                if (start) begin
                    x_reg    <= rate_p1;
                    p_reg    <= 6'd47;
                    step_reg <= 3'd5;
                    pass_reg <= 1'b0;
                end
            end
            LV_NORM: begin
                // Binary search for the leading one, halving the stride.
                if (hi_zero) begin
                    x_reg <= x_reg << sh;
                    p_reg <= p_reg - sh[5:0];
                end
                step_reg <= step_reg - 3'd1;
            end
            LV_INTERP: begin
                prod_reg <= 57'(t1 - t0) * 57'(frac);
                base_reg <= {p_reg, FW'(0)} + LW'(t0);
            end
            LV_MUL: begin
                if (!pass_reg) begin
                    lr_reg   <= log_val;
                    x_reg    <= fs_x;
                    p_reg    <= 6'd47;
                    step_reg <= 3'd5;
                    pass_reg <= 1'b1;
                end else begin
                    lf_reg <= log_val;
                    if (log_val == '0) begin
                        q_reg <= (lr_reg != '0) ? '1 : '0;
                    end else if (lr_reg >= log_val) begin
                        q_reg <= '1;
                    end else begin
                        rem_reg <= lr_reg;
                        q_reg   <= '0;
                        cnt_reg <= 4'd15;
                    end
                end
            end
            LV_DIV: begin
                rem_reg <= ge ? LW'(rem_sh - {1'b0, lf_reg}) : rem_sh[LW-1:0];
                q_reg   <= {q_reg[14:0], ge};
                cnt_reg <= cnt_reg - 4'd1;
            end
            default: ;
        endcase
    end

endmodule

[sv/counter_rate_log_ema_monitor.sv]
// Top level of the counter rate monitor: channels, configuration registers,
// delta capture, the rate and level lanes and the merging stage.
// Depends on crlem_pkg, crlem_rate_lane and crlem_level_lane.
//
// Usage: each input transaction on s_ carries eight running counters, the
// interval in ms and the memory pressure; each one produces exactly one
// result transaction on m_ with eight Q0.16 levels and the priming flag.
// The first transaction after reset only stores the counters and returns
// priming=1 with all levels zero. Every later item runs in two phases.
// Eight rate lanes divide the scaled deltas by the interval, one quotient
// bit per cycle; the merging stage adds the read and write rates. Seven
// level lanes then take two table-interpolated log2 values and a 16-step
// ratio, and memory pressure is averaged beside them. The result comes
// sooner when rates saturate or a level clamps; the 64-step rate divider
// takes the largest share of the time. s_tready is high only while the
// block is idle, so a new item is taken only after the last result has
// moved into the output register. A finished result sits in the output
// register until it is taken; a stalled receiver holds back the next result
// but not the computation of the accepted item. Reset (aresetn low,
// synchronous) clears the levels, the priming state and the configuration
// registers to their defaults. cfg writes take effect at once and are meant
// to be made while the block is idle.
module counter_rate_log_ema_monitor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // exec_count, rx_bytes, tx_bytes, switch_count, read_bytes, write_bytes,
    // retransmit_count, irq_count, interval_ms, mem_pressure, zero fill
    input  logic [crlem_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // exec_level, rx_level, tx_level, switch_level, io_level, retx_level,
    // irq_level, mem_level
    output logic [crlem_pkg::M_DATA_W-1:0]      m_tdata,
    // priming
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [crlem_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [crlem_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int NC = crlem_pkg::NUM_CNT;
    localparam int NL = crlem_pkg::NUM_LEVEL;
    localparam int CW = crlem_pkg::CNT_W;
    localparam int DW = crlem_pkg::DEN_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RATE  = 4'b0010,
        ST_LEVEL = 4'b0100,
        ST_OUT   = 4'b1000
    } top_state_t;

    top_state_t     state_reg;
    logic [15:0]    smoothing_reg;
    logic [31:0]    fs_reg [crlem_pkg::NUM_FS];
    logic           primed_reg;
    logic           prime_out_reg;
    logic           go_rate_reg;
    logic           go_level_reg;
    logic           m_tvalid_reg;
    logic [127:0]   m_tdata_reg;
    logic           m_tuser_reg;

    logic [CW-1:0]  last_reg  [NC];
    logic [CW-1:0]  delta_reg [NC];
    logic [DW-1:0]  den_ms_reg;
    logic [DW-1:0]  den_kb_reg;
    logic [9:0]     mp_reg;
    logic [15:0]    alpha_reg;
    logic [15:0]    alpha_retx_reg;
    logic [16:0]    mem_est_reg;
    logic [15:0]    mem_x_reg;
    logic [15:0]    mem_level_reg;

    logic           accept;
    logic [CW-1:0]  count_in [NC];
    logic [15:0]    interval;
    logic [15:0]    ms_eff;
    logic [31:0]    alpha_full;
    logic [31:0]    alpha_retx_full;
    logic [NC-1:0]  rate_busy;
    logic [CW-1:0]  rate_q [NC];
    logic [64:0]    io_sum;
    logic [CW-1:0]  io_rate;
    logic [NL-1:0]  level_busy;
    logic [CW-1:0]  lvl_rate [NL];
    logic [31:0]    lvl_fs [NL];
    logic [15:0]    lvl_alpha [NL];
    logic [15:0]    lvl_out [NL];

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    for (genvar i = 0; i < NC; i++) begin : g_unpack
        assign count_in[i] = s_tdata[CW*i +: CW];
    end
    assign interval = s_tdata[527:512];

    // A zero interval stands for 100 ms.
    assign ms_eff          = (interval == '0) ? 16'd100 : interval;
    assign alpha_full      = 32'(smoothing_reg) * 32'(crlem_pkg::ALPHA_98);
    assign alpha_retx_full = 32'(smoothing_reg >> 1) * 32'(crlem_pkg::ALPHA_98);

    // Rate lanes, one per counter.
    for (genvar i = 0; i < NC; i++) begin : g_rate
        crlem_rate_lane u_rate (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (go_rate_reg),
            .delta   (delta_reg[i]),
            .den     (crlem_pkg::KB_LANES[i] ? den_kb_reg : den_ms_reg),
            .busy    (rate_busy[i]),
            .rate    (rate_q[i])
        );
    end

    // Merging stage: block read and write rates combine with saturation.
    assign io_sum  = {1'b0, rate_q[4]} + {1'b0, rate_q[5]};
    assign io_rate = io_sum[64] ? '1 : io_sum[63:0];

    assign lvl_rate[0] = rate_q[0];
    assign lvl_rate[1] = rate_q[1];
    assign lvl_rate[2] = rate_q[2];
    assign lvl_rate[3] = rate_q[3];
    assign lvl_rate[4] = io_rate;
    assign lvl_rate[5] = rate_q[6];
    assign lvl_rate[6] = rate_q[7];

    assign lvl_fs[0] = fs_reg[0];
    assign lvl_fs[1] = fs_reg[1];
    assign lvl_fs[2] = fs_reg[1];
    assign lvl_fs[3] = fs_reg[2];
    assign lvl_fs[4] = fs_reg[3];
    assign lvl_fs[5] = fs_reg[4];
    assign lvl_fs[6] = fs_reg[5];

    // Retransmits use half the smoothing.
    for (genvar i = 0; i < NL; i++) begin : g_level
        assign lvl_alpha[i] = (i == 5) ? alpha_retx_reg : alpha_reg;
        crlem_level_lane u_level (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .start      (go_level_reg),
            .rate       (lvl_rate[i]),
            .full_scale (lvl_fs[i]),
            .alpha      (lvl_alpha[i]),
            .busy       (level_busy[i]),
            .level      (lvl_out[i])
        );
    end

    // Control, configuration and the levels that persist across items.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            prime_out_reg <= 1'b0;
            go_rate_reg   <= 1'b0;
            go_level_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            mem_level_reg <= '0;
            smoothing_reg <= 16'd32768;
            fs_reg[0]     <= 32'd250;
            fs_reg[1]     <= 32'd50000;
            fs_reg[2]     <= 32'd120000;
            fs_reg[3]     <= 32'd80000;
            fs_reg[4]     <= 32'd50;
            fs_reg[5]     <= 32'd200000;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    crlem_pkg::REG_SMOOTHING: smoothing_reg <= cfg_wdata[15:0];
                    crlem_pkg::REG_EXEC_FS:   fs_reg[0] <= cfg_wdata;
                    crlem_pkg::REG_NET_FS:    fs_reg[1] <= cfg_wdata;
                    crlem_pkg::REG_SWITCH_FS: fs_reg[2] <= cfg_wdata;
                    crlem_pkg::REG_IO_FS:     fs_reg[3] <= cfg_wdata;
                    crlem_pkg::REG_RETX_FS:   fs_reg[4] <= cfg_wdata;
                    crlem_pkg::REG_IRQ_FS:    fs_reg[5] <= cfg_wdata;
                    default: ;
                endcase
            end

            go_rate_reg  <= 1'b0;
            go_level_reg <= 1'b0;
            if (go_level_reg) begin
                mem_level_reg <= crlem_pkg::smooth(mem_level_reg, mem_x_reg,
                                                   crlem_pkg::ALPHA_MEM);
            end
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (!primed_reg) begin
                            primed_reg    <= 1'b1;
                            prime_out_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end else begin
                            prime_out_reg <= 1'b0;
                            go_rate_reg   <= 1'b1;
                            state_reg     <= ST_RATE;
                        end
                    end
                end
                ST_RATE: begin
                    if (!go_rate_reg && rate_busy == '0) begin
                        go_level_reg <= 1'b1;
                        state_reg    <= ST_LEVEL;
                    end
                end
                ST_LEVEL: begin
                    if (!go_level_reg && level_busy == '0) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < NC; i++) begin
                last_reg[i]  <= count_in[i];
                delta_reg[i] <= count_in[i] - last_reg[i];
            end
            den_ms_reg     <= DW'(ms_eff);
            den_kb_reg     <= {ms_eff, 10'd0};
            mp_reg         <= s_tdata[537:528];
            alpha_reg      <= alpha_full[31:16];
            alpha_retx_reg <= alpha_retx_full[31:16];
        end

        // pressure * 65536 / 1000 by reciprocal, then one downward correction.
        mem_est_reg <= 17'((27'(mp_reg) * 27'd67109) >> 10);
        if (mp_reg >= 10'd1000) begin
            mem_x_reg <= '1;
        end else if (27'(mem_est_reg) * 27'd1000 > (27'(mp_reg) << 16)) begin
            mem_x_reg <= 16'(mem_est_reg - 17'd1);
        end else begin
            mem_x_reg <= mem_est_reg[15:0];
        end

        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tuser_reg <= prime_out_reg;
            m_tdata_reg <= {mem_level_reg, lvl_out[6], lvl_out[5], lvl_out[4],
                            lvl_out[3], lvl_out[2], lvl_out[1], lvl_out[0]};
        end
    end

endmodule

[sv/crlem_checker.sv]
// Port-level checks of the counter rate monitor and the bind that attaches
// them to the top level. Depends on counter_rate_log_ema_monitor.
module crlem_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // A result that waits keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The priming result carries no level.
    a_prime_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("priming result with nonzero levels");

    // One item at a time: after an accepted transaction the input closes.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input reopened right after acceptance");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind counter_rate_log_ema_monitor crlem_checker u_crlem_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/counter_rate_log_ema_monitor_tb.sv]
// Self-checking testbench for counter_rate_log_ema_monitor: directed vectors, then
// randomized counter snapshots under several register settings, with random stalls.
// Depends on crlem_pkg and the monitor RTL.
module counter_rate_log_ema_monitor_tb;
    import crlem_pkg::*;

    // Index beyond the register file; writes to it must be ignored.
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int NUM_PHASES = 8;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [LEVEL_W*8-1:0] levels;
        logic                 priming;
    } level_snapshot_t;

    // One directed vector. Where has_typed is set, the expected levels are written
    // out here rather than taken from the predictor.
    typedef struct {
        logic [CNT_W*8-1:0]   counts;
        logic [15:0]          interval_ms;
        logic [9:0]           pressure;
        bit                   has_typed;
        logic                 typed_priming;
        logic [LEVEL_W*8-1:0] typed_levels;
    } vector_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    counter_rate_log_ema_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Predictor state: a private copy of the monitor's registers and history.
    logic [31:0]      log2_frac [0:LOG_TAB_SIZE];
    logic [15:0]      smooth_factor;
    logic [31:0]      full_scale [0:NUM_FS-1];
    logic [CNT_W-1:0] prev_count [0:NUM_CNT-1];
    logic             seen_first;
    logic [15:0]      level_hist [0:NUM_CNT-1];

    level_snapshot_t  pending_levels [$];
    int               fail_count;
    int               cycle_count;
    bit               no_idle;
    logic [CNT_W-1:0] stim_count [0:NUM_CNT-1];
    int               out_stall;

    // Fraction of log2(1 + i/N) in Q.24, found bit by bit through repeated squaring.
    function automatic logic [31:0] log2_frac_point(input int i);
        logic [63:0] x;
        logic [31:0] y;
        x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TAB_SIZE);
        y = 0;
        for (int b = 0; b < LOG_FRAC; b++) begin
            x = (x * x) >> 30;
            y = y << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                y[0] = 1'b1;
            end
        end
        return y;
    endfunction

    // log2 of a Q.16 value of at least one, in Q.24, with linear interpolation.
    function automatic logic [63:0] log2_q24(input logic [63:0] v);
        int          lead;
        logic [63:0] mant;
        logic [63:0] prod;
        logic [63:0] idx;
        logic [63:0] frac_rem;
        logic [63:0] lo_pt;
        logic [63:0] hi_pt;
        lead = 63;
        while (lead > 16 && v[lead] == 1'b0)
            lead--;
        if (lead >= 32)
            mant = (v >> (lead - 32)) & 64'hFFFF_FFFF;
        else
            mant = (v << (32 - lead)) & 64'hFFFF_FFFF;
        prod = mant * LOG_TAB_SIZE;
        idx = prod >> 32;
        frac_rem = prod & 64'hFFFF_FFFF;
        lo_pt = log2_frac[idx];
        hi_pt = log2_frac[idx + 1];
        return (64'(lead - 16) << LOG_FRAC) + lo_pt + (((hi_pt - lo_pt) * frac_rem) >> 32);
    endfunction

    // Events per second in Q48.16, saturating at all ones.
    function automatic logic [63:0] rate_per_sec(input logic [63:0] delta,
                                                 input logic [63:0] den);
        logic [127:0] quo;
        quo = ((128'(delta) * 128'd1000) << 16) / 128'(den);
        if (quo[127:64] != 0)
            return '1;
        return quo[63:0];
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return s[64] ? '1 : s[63:0];
    endfunction

    // Log-scaled level of a rate against its full scale, Q0.16, clamped to one.
    function automatic logic [15:0] scaled_level(input logic [63:0] rate,
                                                 input logic [31:0] fs);
        logic [63:0] lr;
        logic [63:0] lf;
        logic [63:0] q;
        lr = log2_q24(add_sat(rate, 64'd65536));
        lf = log2_q24((64'(fs) << 16) + 64'd65536);
        if (lf == 0)
            return (lr != 0) ? 16'hFFFF : 16'h0000;
        q = (lr << LEVEL_W) / lf;
        return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic logic [15:0] ema(input logic [15:0] prev, input logic [15:0] x,
                                        input logic [63:0] a);
        logic [63:0] s;
        s = (a * prev + (64'd65536 - a) * x + 64'd32768) >> 16;
        return s[15:0];
    endfunction

    // Advances the predictor by one accepted snapshot and returns its result.
    function automatic level_snapshot_t predict_levels(input logic [S_DATA_W-1:0] item);
        level_snapshot_t  res;
        logic [63:0]      ms;
        logic [63:0]      mp;
        logic [63:0]      delta [0:NUM_CNT-1];
        logic [63:0]      rate [0:6];
        logic [15:0]      target [0:NUM_CNT-1];
        logic [63:0]      a_main;
        logic [63:0]      a_retx;
        logic [63:0]      cur;
        ms = item[CNT_W*8 +: 16];
        mp = item[CNT_W*8 + 16 +: 10];
        res.priming = 1'b0;
        if (!seen_first) begin
            for (int i = 0; i < NUM_CNT; i++) begin
                prev_count[i] = item[i*CNT_W +: CNT_W];
                level_hist[i] = 0;
            end
            seen_first = 1'b1;
            res.priming = 1'b1;
            res.levels = '0;
            return res;
        end
        if (ms == 0)
            ms = 100;
        for (int i = 0; i < NUM_CNT; i++) begin
            cur = item[i*CNT_W +: CNT_W];
            delta[i] = cur - prev_count[i];
            prev_count[i] = cur;
        end
        // Lane order: exec, rx, tx, switch, read+write, retx, irq.
        rate[0] = rate_per_sec(delta[0], ms);
        rate[1] = rate_per_sec(delta[1], ms * 1024);
        rate[2] = rate_per_sec(delta[2], ms * 1024);
        rate[3] = rate_per_sec(delta[3], ms);
        rate[4] = add_sat(rate_per_sec(delta[4], ms * 1024),
                          rate_per_sec(delta[5], ms * 1024));
        rate[5] = rate_per_sec(delta[6], ms);
        rate[6] = rate_per_sec(delta[7], ms);
        target[0] = scaled_level(rate[0], full_scale[0]);
        target[1] = scaled_level(rate[1], full_scale[1]);
        target[2] = scaled_level(rate[2], full_scale[1]);
        target[3] = scaled_level(rate[3], full_scale[2]);
        target[4] = scaled_level(rate[4], full_scale[3]);
        target[5] = scaled_level(rate[5], full_scale[4]);
        target[6] = scaled_level(rate[6], full_scale[5]);
        if (mp >= 1000)
            target[7] = 16'hFFFF;
        else
            target[7] = 16'((mp << 16) / 1000);
        a_main = (64'(smooth_factor) * ALPHA_98) >> 16;
        a_retx = (64'(smooth_factor >> 1) * ALPHA_98) >> 16;
        for (int i = 0; i < NUM_LEVEL; i++)
            level_hist[i] = ema(level_hist[i], target[i], (i == 5) ? a_retx : a_main);
        level_hist[7] = ema(level_hist[7], target[7], 64'(ALPHA_MEM));
        for (int i = 0; i < NUM_CNT; i++)
            res.levels[i*LEVEL_W +: LEVEL_W] = level_hist[i];
        return res;
    endfunction

    // Gap length: mostly none or short, now and then long; none in idle-free stretches.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Writes one register at a falling edge and mirrors it in the predictor.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == REG_SMOOTHING)
            smooth_factor = val[15:0];
        else if (idx != REG_UNMAPPED)
            full_scale[idx - REG_EXEC_FS] = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [15:0] sm, input logic [31:0] fs [0:NUM_FS-1]);
        write_reg(REG_SMOOTHING, 32'(sm));
        write_reg(REG_EXEC_FS,   fs[0]);
        write_reg(REG_NET_FS,    fs[1]);
        write_reg(REG_SWITCH_FS, fs[2]);
        write_reg(REG_IO_FS,     fs[3]);
        write_reg(REG_RETX_FS,   fs[4]);
        write_reg(REG_IRQ_FS,    fs[5]);
    endtask

    // Offers one snapshot after a random gap and holds it until the transaction
    // completes. Returns at the falling edge after acceptance with tvalid still high.
    task automatic send_snapshot(input logic [S_DATA_W-1:0] item, input bit has_typed,
                                 input level_snapshot_t typed);
        int              gap;
        level_snapshot_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do
            @(posedge aclk);
        while (!s_tready);
        predicted = predict_levels(item);
        pending_levels.push_back(has_typed ? typed : predicted);
        @(negedge aclk);
    endtask

    function automatic logic [S_DATA_W-1:0] pack_snapshot(input logic [CNT_W*8-1:0] counts,
                                                          input logic [15:0] ms,
                                                          input logic [9:0] mp);
        return {6'd0, mp, ms, counts};
    endfunction

    // Waits for every outstanding result, then lets the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Random next counter value: mostly plausible growth, sometimes a jump
    // anywhere in 64 bits or a wrap through zero.
    function automatic logic [63:0] next_count(input logic [63:0] cur);
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return cur;
        if (r < 11)
            return cur + $urandom_range(0, 200000);
        if (r < 14)
            return cur + 64'($urandom);
        if (r < 16)
            return cur + {32'($urandom_range(0, 255)), 32'($urandom)};
        if (r < 18)
            return {32'($urandom), 32'($urandom)};
        return cur - $urandom_range(1, 1000);
    endfunction

    // Output side: random back-pressure; every result is checked against the
    // oldest expectation field by field.
    always @(negedge aclk) begin
        logic rdy;
        if (!aresetn) begin
            rdy = 1'b0;
            out_stall = 0;
        end else if (out_stall > 0) begin
            rdy = 1'b0;
            out_stall--;
        end else begin
            rdy = 1'b1;
            out_stall = pick_gap();
        end
        m_tready <= rdy;
    end

    always @(posedge aclk) begin
        level_snapshot_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                $display("%0t: result with no transaction outstanding: levels %h priming %b",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_levels.pop_front();
                if (m_tuser[0] !== want.priming) begin
                    $display("%0t: priming expected %b actual %b",
                             $time, want.priming, m_tuser[0]);
                    fail_count++;
                end
                for (int i = 0; i < NUM_CNT; i++) begin
                    if (m_tdata[i*LEVEL_W +: LEVEL_W] !== want.levels[i*LEVEL_W +: LEVEL_W]) begin
                        $display("%0t: level %0d expected %h actual %h", $time, i,
                                 want.levels[i*LEVEL_W +: LEVEL_W],
                                 m_tdata[i*LEVEL_W +: LEVEL_W]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        vector_t          vectors [$];
        vector_t          v;
        level_snapshot_t  typed;
        logic [31:0]      fs [0:NUM_FS-1];
        logic [15:0]      sm;
        logic [CNT_W*8-1:0] counts;
        logic [15:0]      ms;
        int               r;

        fail_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        aresetn = 1'b0;

        for (int i = 0; i <= LOG_TAB_SIZE; i++)
            log2_frac[i] = (i == LOG_TAB_SIZE) ? (32'd1 << LOG_FRAC) : log2_frac_point(i);
        smooth_factor = 16'd32768;
        full_scale[0] = 250;
        full_scale[1] = 50000;
        full_scale[2] = 120000;
        full_scale[3] = 80000;
        full_scale[4] = 50;
        full_scale[5] = 200000;
        seen_first = 1'b0;
        for (int i = 0; i < NUM_CNT; i++) begin
            prev_count[i] = 0;
            level_hist[i] = 0;
        end

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, under the reset settings. The first snapshot only primes;
        // a second one with the same counters and no pressure leaves all levels at
        // zero. The rest cover the zero interval, extreme intervals, counters
        // wrapping through zero, saturated rates and pressure at and above full.
        v = '{counts: '0, interval_ms: 16'd100, pressure: 10'd0, has_typed: 1'b1,
              typed_priming: 1'b1, typed_levels: '0};
        vectors.push_back(v);
        v.typed_priming = 1'b0;
        v.interval_ms = 16'd0;
        vectors.push_back(v);
        v.has_typed = 1'b0;
        for (int i = 0; i < NUM_CNT; i++)
            v.counts[i*CNT_W +: CNT_W] = 64'(1000 * (i + 1));
        vectors.push_back(v);
        v.counts = '1;
        v.interval_ms = 16'd1;
        v.pressure = 10'd1000;
        vectors.push_back(v);
        v.counts = '0;
        v.interval_ms = 16'hFFFF;
        v.pressure = 10'h3FF;
        vectors.push_back(v);
        v.counts = {8{64'h8000_0000_0000_0000}};
        v.interval_ms = 16'd1000;
        v.pressure = 10'd999;
        vectors.push_back(v);
        v.counts = {8{64'h8000_0000_0000_0001}};
        v.interval_ms = 16'd1;
        v.pressure = 10'd1;
        vectors.push_back(v);
        v.counts = {8{64'h0000_0000_FFFF_FFFF}};
        v.interval_ms = 16'hFFFF;
        v.pressure = 10'd500;
        vectors.push_back(v);
        v.counts = {8{64'hFFFF_FFFF_0000_0000}};
        v.interval_ms = 16'h8000;
        v.pressure = 10'd0;
        vectors.push_back(v);
        v.counts = {8{64'h5555_5555_5555_5555}};
        v.interval_ms = 16'h5555;
        v.pressure = 10'h2AA;
        vectors.push_back(v);
        v.counts = {8{64'hAAAA_AAAA_AAAA_AAAA}};
        v.interval_ms = 16'hAAAA;
        v.pressure = 10'h155;
        vectors.push_back(v);

        foreach (vectors[k]) begin
            typed.priming = vectors[k].typed_priming;
            typed.levels = vectors[k].typed_levels;
            send_snapshot(pack_snapshot(vectors[k].counts, vectors[k].interval_ms,
                                        vectors[k].pressure),
                          vectors[k].has_typed, typed);
        end
        for (int i = 0; i < NUM_CNT; i++)
            stim_count[i] = vectors[vectors.size() - 1].counts[i*CNT_W +: CNT_W];

        // Random part: each phase starts idle, loads a register setting and then
        // streams snapshots. Waiting for the queue to empty between phases is also
        // where the sender holds off until every result is in.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    // Reset defaults, written back explicitly.
                    sm = 16'd32768;
                    fs = '{250, 50000, 120000, 80000, 50, 200000};
                end
                1: begin
                    sm = 16'd0;
                    fs = '{1, 1, 1, 1, 1, 1};
                end
                2: begin
                    sm = 16'hFFFF;
                    fs = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                end
                3: begin
                    // A full scale of zero turns any activity into level one.
                    sm = 16'($urandom);
                    fs = '{0, 0, 0, 0, 0, 0};
                end
                default: begin
                    sm = 16'($urandom);
                    for (int i = 0; i < NUM_FS; i++)
                        fs[i] = ($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(1, 300000);
                end
            endcase
            write_all_regs(sm, fs);
            if (ph == 4)
                write_reg(REG_UNMAPPED, $urandom);
            no_idle = (ph % 3 == 1);

            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                for (int i = 0; i < NUM_CNT; i++) begin
                    stim_count[i] = next_count(stim_count[i]);
                    counts[i*CNT_W +: CNT_W] = stim_count[i];
                end
                r = $urandom_range(0, 19);
                if (r == 0)
                    ms = 16'd0;
                else if (r < 3)
                    ms = 16'($urandom);
                else
                    ms = 16'($urandom_range(1, 2000));
                typed.priming = 1'b0;
                typed.levels = '0;
                send_snapshot(pack_snapshot(counts, ms, 10'($urandom_range(0, 1023))),
                              1'b0, typed);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
